### hw/rtl/rsa_modexp_cipher_assert.svh
// Assertion macros used by the checker file of the modular exponentiation block.
`ifndef RSA_MODEXP_CIPHER_ASSERT_SVH
`define RSA_MODEXP_CIPHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RMX_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RMX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/rmx_pkg.sv
// Package with widths, register indexes, command types and the modular add.
`default_nettype none

package rmx_pkg;

  localparam int unsigned WordWidth     = 64;
  localparam int unsigned CfgIndexWidth = 8;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] RegKeyExponent = 8'd0;
  localparam logic [CfgIndexWidth-1:0] RegModulus     = 8'd1;

  typedef logic [WordWidth-1:0] word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a message and set up the exponent loop
    logic start_acc;  // start a multiply of acc by base
    logic start_sq;   // start a multiply of base by base
    logic step;       // one double-and-add step of the running multiply
    logic wb_acc;     // write the product back to acc
    logic wb_base;    // write the product back to base and shift the exponent
    logic publish;    // move the finished word into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_err;  // message was not below the modulus
    logic exp_zero;   // no exponent bits remain
    logic exp_lsb;    // current exponent bit
    logic mul_done;   // multiplier operand is exhausted
  } dp_status_t;

  // (x + y) mod n for x and y already below n; never overflows the word.
  function automatic word_t residue_add(input word_t x, input word_t y, input word_t n);
    word_t gap;
    gap = n - y;
    return (x >= gap) ? (x - gap) : (x + y);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rmx_datapath.sv
// Datapath: configuration registers, exponent loop registers and bit-serial multiplier.
`default_nettype none

module rmx_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [rmx_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire rmx_pkg::word_t                    cfg_data,
  input  wire rmx_pkg::word_t                    message,
  input  wire rmx_pkg::dp_cmd_t                  cmd,
  output rmx_pkg::dp_status_t                    status,
  output rmx_pkg::word_t                         result,
  output logic                                   range_error
);

  rmx_pkg::word_t key_exponent;
  rmx_pkg::word_t modulus;
  rmx_pkg::word_t acc;
  rmx_pkg::word_t base;
  rmx_pkg::word_t exp_bits;
  rmx_pkg::word_t mx;
  rmx_pkg::word_t my;
  rmx_pkg::word_t prod;
  logic           err;

  rmx_pkg::word_t prod_next;
  rmx_pkg::word_t mx_next;

  // Configuration registers; both reset to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_exponent <= '0;
      modulus      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == rmx_pkg::RegKeyExponent) begin
        key_exponent <= cfg_data;
      end else if (cfg_index == rmx_pkg::RegModulus) begin
        modulus <= cfg_data;
      end
    end
  end

  // One double-and-add step: both modular adds run side by side.
  always_comb begin
    prod_next = my[0] ? rmx_pkg::residue_add(prod, mx, modulus) : prod;
    mx_next   = rmx_pkg::residue_add(mx, mx, modulus);
  end

  // Exponent loop registers and the multiplier operands.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base     <= message;
      acc      <= (modulus == rmx_pkg::word_t'(1)) ? '0 : rmx_pkg::word_t'(1);
      exp_bits <= key_exponent;
      err      <= (message >= modulus);
    end
    if (cmd.start_acc) begin
      mx   <= acc;
      my   <= base;
      prod <= '0;
    end else if (cmd.start_sq) begin
      mx   <= base;
      my   <= base;
      prod <= '0;
    end else if (cmd.step) begin
      mx   <= mx_next;
      my   <= my >> 1;
      prod <= prod_next;
    end
    if (cmd.wb_acc) begin
      acc <= prod;
    end
    if (cmd.wb_base) begin
      base     <= prod;
      exp_bits <= exp_bits >> 1;
    end
  end

  // Output register: holds the word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      result      <= err ? base : acc;
      range_error <= err;
    end
  end

  assign status.range_err = err;
  assign status.exp_zero  = (exp_bits == '0);
  assign status.exp_lsb   = exp_bits[0];
  assign status.mul_done  = (my == '0);

endmodule

`default_nettype wire

### hw/rtl/rmx_ctrl.sv
// Controller: sequences loading, square-and-multiply passes and output handshake.
`default_nettype none

module rmx_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire rmx_pkg::dp_status_t status,
  output rmx_pkg::dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXP,
    S_MUL_ACC,
    S_MUL_SQ,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Command decode and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXP;
        end
      end
      S_EXP: begin
        if (status.range_err || status.exp_zero) begin
          state_next = S_FINISH;
        end else if (status.exp_lsb) begin
          cmd.start_acc = 1'b1;
          state_next    = S_MUL_ACC;
        end else begin
          cmd.start_sq = 1'b1;
          state_next   = S_MUL_SQ;
        end
      end
      S_MUL_ACC: begin
        if (status.mul_done) begin
          cmd.wb_acc   = 1'b1;
          cmd.start_sq = 1'b1;
          state_next   = S_MUL_SQ;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_MUL_SQ: begin
        if (status.mul_done) begin
          cmd.wb_base = 1'b1;
          state_next  = S_EXP;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and the registered output-valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rsa_modexp_cipher.sv
// Usage notes:
// A 64-bit message word enters on in_valid/in_ready; the word message^key_exponent
// mod modulus leaves on out_valid/out_ready with range_error low. A message not
// below the modulus leaves unchanged with range_error high. The configuration
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready; index 0 is
// the exponent, index 1 the modulus, other indexes are ignored.
// Write it only while no word is in flight.
// For every exponent bit up to the highest set one, the block takes a decision
// step, then a multiply pass where the bit is set, then a squaring pass. A pass
// runs until its multiplier operand is exhausted; the shared double-and-add
// multiplier takes one operand bit per cycle. One word is worked on at a time.
// The output register lets the next word enter while a finished word waits; a
// stalled receiver leaves the next result in the loop registers, with the input
// closed, until the output register is free.
// Reset clears both configuration registers to zero and empties the block.
`default_nettype none

module rsa_modexp_cipher (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rmx_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [rmx_pkg::WordWidth-1:0]     cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [rmx_pkg::WordWidth-1:0]     message,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [rmx_pkg::WordWidth-1:0]          result,
  output logic                                   range_error
);

  rmx_pkg::dp_cmd_t    cmd;
  rmx_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  // Sequencer.
  rmx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and storage.
  rmx_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .message     (message),
    .cmd         (cmd),
    .status      (status),
    .result      (result),
    .range_error (range_error)
  );

endmodule

`default_nettype wire

### hw/rtl/rmx_checker.sv
// Port-level checker for the modular exponentiation block, with its bind.
`default_nettype none

`include "rsa_modexp_cipher_assert.svh"

module rmx_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [rmx_pkg::WordWidth-1:0] result,
  input wire logic                          range_error
);

  // A word that is offered stays offered, unchanged, until taken.
  `RMX_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(result) && $stable(range_error))

  // The block works on one word at a time: ready drops once a word enters.
  `RMX_ASSERT_NEXT(a_in_single, clk, rst, in_valid && in_ready, !in_ready)

  // Nothing is offered right after reset.
  `RMX_ASSERT_IMPLY(a_out_reset, clk, rst, $past(rst), !out_valid)

  // With no result waiting, none can appear in the cycle right after a word enters.
  `RMX_ASSERT_NEXT(a_no_early_out, clk, rst, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind rsa_modexp_cipher rmx_checker u_rmx_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result      (result),
  .range_error (range_error)
);

`default_nettype wire

### tb/tb_rsa_modexp_cipher.sv
// Self-checking testbench for the 64-bit modular exponentiation block.
`timescale 1ns / 100ps

module tb_rsa_modexp_cipher;

  localparam int unsigned QuietLimit = 50000;
  localparam logic [rmx_pkg::CfgIndexWidth-1:0] RegUnused = 8'd2;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] BigPrime = 64'hFFFF_FFFF_FFFF_FFC5;

  typedef enum int {
    FLOW_FREE,
    FLOW_SEND_GAPS,
    FLOW_RECV_STALLS,
    FLOW_BOTH
  } flow_mode_t;

  typedef struct packed {
    logic [63:0] value;
    logic        range_err;
  } cipher_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [rmx_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] message = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] result;
  logic        range_error;

  // Shadow copy of the two registers, as seen by the predictor.
  logic [63:0] exponent_shadow = '0;
  logic [63:0] modulus_shadow = '0;

  logic [63:0]  plain_words[$];
  cipher_word_t cipher_words[$];
  flow_mode_t   flow = FLOW_FREE;
  int           words_queued = 0;
  int           words_accepted = 0;
  int           words_checked = 0;
  int           rejects_seen = 0;
  int           fail_count = 0;
  int           quiet_cycles = 0;
  int           settings_used = 0;

  rsa_modexp_cipher dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .message     (message),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result),
    .range_error (range_error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Modular add of two residues that cannot overflow the 64-bit word.
  function automatic logic [63:0] mod_sum(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] n);
    logic [63:0] room;
    room = n - b;
    return (a >= room) ? (a - room) : (a + b);
  endfunction

  // Modular product by double-and-add over the bits of b.
  function automatic logic [63:0] mod_product(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] n);
    logic [63:0] acc;
    acc = '0;
    for (int i = 0; i < 64; i++) begin
      if (b[i]) acc = mod_sum(acc, a, n);
      a = mod_sum(a, a, n);
    end
    return acc;
  endfunction

  // Right-to-left square-and-multiply; all values stay proper residues.
  function automatic logic [63:0] mod_power(input logic [63:0] base, input logic [63:0] e,
                                            input logic [63:0] n);
    logic [63:0] acc;
    acc = (n == 64'd1) ? 64'd0 : 64'd1;
    for (int i = 0; i < 64; i++) begin
      if ((e >> i) == 64'd0) break;
      if (e[i]) acc = mod_product(acc, base, n);
      base = mod_product(base, base, n);
    end
    return acc;
  endfunction

  // Expected output word for one message under the current key.
  function automatic cipher_word_t expected_cipher(input logic [63:0] msg);
    cipher_word_t w;
    if (msg >= modulus_shadow) begin
      w.value = msg;
      w.range_err = 1'b1;
    end else begin
      w.value = mod_power(msg, exponent_shadow, modulus_shadow);
      w.range_err = 1'b0;
    end
    return w;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic bit sender_gaps();
    if (flow == FLOW_SEND_GAPS) return $urandom_range(0, 99) < 56;
    if (flow == FLOW_BOTH) return $urandom_range(0, 99) < 27;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls();
    if (flow == FLOW_RECV_STALLS) return $urandom_range(0, 99) < 56;
    if (flow == FLOW_BOTH) return $urandom_range(0, 99) < 27;
    return 1'b0;
  endfunction

  // Message driver: presents queued words and predicts each accepted one.
  always @(posedge clk) begin
    bit offer;
    if (rst) begin
      in_valid <= 1'b0;
      message <= '0;
    end else begin
      if (in_valid && in_ready) begin
        cipher_words.push_back(expected_cipher(message));
        words_accepted++;
        offer = 1'b1;
      end else begin
        offer = !in_valid;
      end
      if (offer) begin
        if (plain_words.size() > 0 && !sender_gaps()) begin
          in_valid <= 1'b1;
          message <= plain_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted word with the oldest prediction.
  always @(posedge clk) begin
    cipher_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (cipher_words.size() == 0) begin
          $display("%0t: unexpected word: result %h range_error %b",
                   $time, result, range_error);
          fail_count++;
        end else begin
          want = cipher_words.pop_front();
          words_checked++;
          if (range_error) rejects_seen++;
          if (result !== want.value) begin
            $display("%0t: result mismatch: expected %h, got %h", $time, want.value, result);
            fail_count++;
          end
          if (range_error !== want.range_err) begin
            $display("%0t: range_error mismatch: expected %b, got %b",
                     $time, want.range_err, range_error);
            fail_count++;
          end
        end
      end
      out_ready <= !receiver_stalls();
    end
  end

  // Watchdog: ends the run when no channel moves a word for too long.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d words still expected",
                 $time, quiet_cycles, cipher_words.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Writes one register and mirrors it into the shadow copy.
  task automatic write_reg(input logic [rmx_pkg::CfgIndexWidth-1:0] idx,
                           input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == rmx_pkg::RegKeyExponent) exponent_shadow = val;
    else if (idx == rmx_pkg::RegModulus) modulus_shadow = val;
  endtask

  task automatic set_key(input logic [63:0] e, input logic [63:0] n);
    write_reg(rmx_pkg::RegKeyExponent, e);
    write_reg(rmx_pkg::RegModulus, n);
    settings_used++;
  endtask

  task automatic send_word(input logic [63:0] msg);
    plain_words.push_back(msg);
    words_queued++;
  endtask

  // Waits until every queued word has been accepted and its result checked.
  task automatic drain();
    while (plain_words.size() != 0 || words_accepted != words_queued ||
           cipher_words.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A message below the modulus most of the time, otherwise one at or above it.
  function automatic logic [63:0] random_message();
    logic [63:0] r;
    r = rand_word();
    if (modulus_shadow == 64'd0 || $urandom_range(0, 7) == 0) return r | modulus_shadow;
    return r % modulus_shadow;
  endfunction

  initial begin
    logic [63:0] pick_mod;
    logic [63:0] pick_exp;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // After reset the modulus is zero, so every word is rejected.
    flow = FLOW_FREE;
    send_word(64'd0);
    send_word(AllOnes);
    send_word(64'h8000_0000_0000_0000);
    drain();

    // Largest exponent and modulus: the slowest words, and the top residue.
    set_key(AllOnes, AllOnes);
    send_word(64'd0);
    send_word(64'd1);
    send_word(AllOnes - 64'd1);
    send_word(AllOnes);
    send_word(64'h0123_4567_89AB_CDEF);
    drain();

    // Modulus of one: only zero is accepted and it maps to zero, even for exponent zero.
    set_key(64'd0, 64'd1);
    send_word(64'd0);
    send_word(64'd1);
    send_word(AllOnes);
    drain();
    write_reg(rmx_pkg::RegKeyExponent, 64'd7);
    send_word(64'd0);
    drain();

    // Zero exponent under a large prime gives one for every accepted word, then exponent 65537.
    set_key(64'd0, BigPrime);
    send_word(64'd1);
    send_word(BigPrime - 64'd1);
    send_word(BigPrime);
    drain();
    write_reg(rmx_pkg::RegKeyExponent, 64'd65537);
    send_word(64'd2);
    send_word(BigPrime - 64'd1);
    send_word(64'hDEAD_BEEF_0000_0001);
    drain();

    // A write to an unused index must leave the key alone.
    write_reg(RegUnused, AllOnes);
    send_word(64'd12345);
    drain();

    // Random keys, cycling through the flow-control modes.
    for (int ph = 0; ph < 8; ph++) begin
      flow = flow_mode_t'(ph % 4);
      case ($urandom_range(0, 3))
        0: pick_mod = rand_word() | 64'h8000_0000_0000_0000;
        1: pick_mod = (rand_word() >> 32) | 64'd1;
        2: pick_mod = 64'($urandom_range(1, 1000));
        default: pick_mod = ~64'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 7) == 0) pick_exp = rand_word();
      else pick_exp = rand_word() >> $urandom_range(44, 60);
      set_key(pick_exp, pick_mod);
      for (int i = 0; i < 12; i++) begin
        // In one phase the sender holds off until the block has fully emptied.
        if (ph == 5 && i == 6) drain();
        send_word(random_message());
      end
      drain();
    end

    repeat (50) @(posedge clk);
    $display("Checked %0d of %0d words under %0d key settings, %0d of them rejected.",
             words_checked, words_queued, settings_used, rejects_seen);
    if (fail_count == 0 && words_checked == words_queued) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
